// ===== hdl/quoted_word_splitter_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quoted word splitter
// Shorthand for clocked assertions on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUOTED_WORD_SPLITTER_TOP_MACROS_SVH
`define QUOTED_WORD_SPLITTER_TOP_MACROS_SVH

// The expression must never be true.
`define QWS_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("quoted word splitter: forbidden condition seen");

// When the antecedent holds, the consequent holds in the same cycle.
`define QWS_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quoted word splitter: same-cycle implication failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define QWS_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quoted word splitter: next-cycle implication failed");

`endif

// ===== hdl/qws_pkg.sv =====
// ----------------------------------------------------------------------------
// Quoted word splitter package
// Widths, character codes, byte classes, scan modes and shared types.
// ----------------------------------------------------------------------------
package qws_pkg;

    localparam int unsigned MAX_WORDS_DEF  = 1024;
    localparam int unsigned MAX_OFFSET_DEF = 65536;
    localparam int unsigned CAP_RESET      = 64;
    localparam int unsigned QUEUE_DEPTH    = 4;

    localparam int unsigned CH_W     = 8;
    localparam int unsigned CAP_W    = 11;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned NUM_W    = 10;
    localparam int unsigned TOTAL_W  = 11;
    localparam int unsigned STATUS_W = 2;

    localparam logic [CH_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CHAR_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CHAR_LF     = 8'h0A;
    localparam logic [CH_W-1:0] CHAR_CR     = 8'h0D;
    localparam logic [CH_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CHAR_QUOTE  = 8'h22;
    localparam logic [CH_W-1:0] CHAR_BSLASH = 8'h5C;

    typedef enum logic [2:0] {
        CLS_END,
        CLS_SEP,
        CLS_QUOTE,
        CLS_BSLASH,
        CLS_OTHER
    } byte_class_t;

    typedef enum logic [2:0] {
        MODE_BETWEEN,
        MODE_PLAIN,
        MODE_QUOTED,
        MODE_SWALLOW,
        MODE_IGNORE
    } scan_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK,
        STATUS_OPEN_QUOTE,
        STATUS_TOO_MANY
    } split_status_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic byte_class_t classify_byte(input logic [CH_W-1:0] b);
        byte_class_t c;
        if (b == CHAR_NUL)
        begin
            c = CLS_END;
        end
        else if (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR)
        begin
            c = CLS_SEP;
        end
        else if (b == CHAR_QUOTE)
        begin
            c = CLS_QUOTE;
        end
        else if (b == CHAR_BSLASH)
        begin
            c = CLS_BSLASH;
        end
        else
        begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

endpackage

// ===== hdl/qws_interfaces.sv =====
// ----------------------------------------------------------------------------
// Quoted word splitter channel interfaces
// Byte input, tag output and capacity configuration channels.
// ----------------------------------------------------------------------------
interface qws_byte_if import qws_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface qws_tag_if import qws_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    position;
    logic                in_word;
    logic                word_begins;
    logic                word_ends;
    logic [NUM_W-1:0]    word_number;
    logic                finished;
    logic [TOTAL_W-1:0]  word_total;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output position, output in_word, output word_begins,
                    output word_ends, output word_number, output finished,
                    output word_total, output status, input ready);
    modport sink   (input valid, input position, input in_word, input word_begins,
                    input word_ends, input word_number, input finished,
                    input word_total, input status, output ready);
endinterface

interface qws_cfg_if import qws_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] word_capacity;

    modport source (output valid, output word_capacity, input ready);
    modport sink   (input valid, input word_capacity, output ready);
endinterface

// ===== hdl/qws_classify.sv =====
// ----------------------------------------------------------------------------
// Quoted word splitter front end
// Accepts bytes while the queue has room and reduces each to its class.
// ----------------------------------------------------------------------------
module qws_classify import qws_pkg::*;
(
    qws_byte_if.sink    byte_in,
    input  queue_stat_t q_stat,
    output logic        push,
    output byte_class_t push_class
);

    assign byte_in.ready = !q_stat.full;
    assign push          = byte_in.valid && byte_in.ready;
    assign push_class    = classify_byte(byte_in.ch);

endmodule

// ===== hdl/qws_queue.sv =====
// ----------------------------------------------------------------------------
// Quoted word splitter class queue
// Small FIFO of byte classes between the front end and the scanner.
// ----------------------------------------------------------------------------
module qws_queue import qws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  byte_class_t push_class,
    input  logic        pop,
    output byte_class_t pop_class,
    output queue_stat_t q_stat
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    byte_class_t      slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_class;
        end
    end

    assign pop_class    = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

// ===== hdl/qws_scan.sv =====
// ----------------------------------------------------------------------------
// Quoted word splitter scanner
// Runs the word scan on queued byte classes and drives the tag output register.
// ----------------------------------------------------------------------------
module qws_scan import qws_pkg::*;
#(
    parameter int unsigned MAX_WORDS  = MAX_WORDS_DEF,
    parameter int unsigned MAX_OFFSET = MAX_OFFSET_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    qws_cfg_if.sink     cfg,
    input  queue_stat_t q_stat,
    input  byte_class_t pop_class,
    output logic        pop,
    qws_tag_if.source   tag_out
);

    localparam int unsigned WCNT_W = $clog2(MAX_WORDS);
    localparam int unsigned OFF_W  = $clog2(MAX_OFFSET);
    localparam int unsigned LIMIT_RESET =
        ((CAP_RESET > MAX_WORDS) ? MAX_WORDS : CAP_RESET) - 1;

    // Capacity register, kept as the word limit it implies.
    logic [WCNT_W-1:0] limit_reg;
    logic [31:0]       cap_clamp;
    logic [WCNT_W-1:0] limit_new;

    always_comb
    begin
        cap_clamp = {{(32 - CAP_W){1'b0}}, cfg.word_capacity};
        if (cap_clamp == 32'd0)
        begin
            cap_clamp = 32'd1;
        end
        if (cap_clamp > 32'(MAX_WORDS))
        begin
            cap_clamp = 32'(MAX_WORDS);
        end
        limit_new = WCNT_W'(cap_clamp - 32'd1);
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= WCNT_W'(LIMIT_RESET);
        end
        else if (cfg.valid && cfg.ready)
        begin
            limit_reg <= limit_new;
        end
    end

    // Scan state and the tag of the previous byte.
    scan_mode_t        mode_reg, mode_next;
    logic              bs_reg, bs_next;
    logic [OFF_W-1:0]  offset_reg;
    logic [WCNT_W-1:0] found_reg, found_next;
    logic              start_reg;
    logic              held_valid_reg;
    logic [OFF_W-1:0]  held_pos_reg;
    logic              held_in_reg;
    logic              held_begin_reg;
    logic              held_end_reg;
    logic [WCNT_W-1:0] held_num_reg;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [POS_W-1:0]    out_pos_reg;
    logic                out_in_reg;
    logic                out_begin_reg;
    logic                out_end_reg;
    logic [NUM_W-1:0]    out_num_reg;
    logic                out_fin_reg;
    logic [TOTAL_W-1:0]  out_total_reg;
    split_status_t       out_status_reg;

    logic is_end, is_sep, is_quote, is_bslash;
    logic produce, step;
    logic cur_in, cur_begin, cur_end, held_end_fix;
    logic [WCNT_W-1:0] cur_num;
    split_status_t     end_status;

    logic [OFF_W+POS_W-1:0]    pos_wide;
    logic [WCNT_W+NUM_W-1:0]   num_wide;
    logic [WCNT_W+TOTAL_W-1:0] total_wide;

    assign is_end    = (pop_class == CLS_END);
    assign is_sep    = (pop_class == CLS_SEP);
    assign is_quote  = (pop_class == CLS_QUOTE);
    assign is_bslash = (pop_class == CLS_BSLASH);

    assign produce = is_end || held_valid_reg;
    assign step    = !q_stat.empty && (!produce || !out_valid_reg || tag_out.ready);
    assign pop     = step;

    // Next scan state.
    always_comb
    begin
        mode_next  = mode_reg;
        bs_next    = bs_reg;
        found_next = found_reg;
        if (is_end)
        begin
            mode_next  = MODE_BETWEEN;
            bs_next    = 1'b0;
            found_next = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_BETWEEN:
                begin
                    if (!is_sep)
                    begin
                        if (found_reg >= limit_reg)
                        begin
                            mode_next = MODE_IGNORE;
                        end
                        else
                        begin
                            found_next = found_reg + 1'b1;
                            if (is_quote)
                            begin
                                mode_next = MODE_QUOTED;
                                bs_next   = 1'b0;
                            end
                            else
                            begin
                                mode_next = MODE_PLAIN;
                            end
                        end
                    end
                end
                MODE_PLAIN:
                begin
                    if (is_sep)
                    begin
                        mode_next = MODE_BETWEEN;
                    end
                end
                MODE_QUOTED:
                begin
                    if (is_quote && !bs_reg)
                    begin
                        mode_next = MODE_SWALLOW;
                    end
                    else
                    begin
                        bs_next = is_bslash;
                    end
                end
                MODE_SWALLOW:
                begin
                    mode_next = MODE_BETWEEN;
                end
                default:
                begin
                    mode_next = MODE_IGNORE;
                end
            endcase
        end
    end

    // Tag of the current byte, and the end mark of the previous one.
    always_comb
    begin
        cur_in       = 1'b0;
        cur_begin    = 1'b0;
        cur_end      = 1'b0;
        cur_num      = held_num_reg;
        held_end_fix = held_end_reg;
        if (is_end)
        begin
            if (held_in_reg && (mode_reg == MODE_PLAIN || mode_reg == MODE_QUOTED))
            begin
                held_end_fix = 1'b1;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_BETWEEN:
                begin
                    if (!is_sep && found_reg < limit_reg)
                    begin
                        cur_in    = 1'b1;
                        cur_begin = 1'b1;
                        cur_num   = found_reg;
                    end
                end
                MODE_PLAIN:
                begin
                    if (is_sep)
                    begin
                        held_end_fix = 1'b1;
                    end
                    else
                    begin
                        cur_in = 1'b1;
                    end
                end
                MODE_QUOTED:
                begin
                    cur_in = 1'b1;
                    if (is_quote && !bs_reg)
                    begin
                        cur_end = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Terminator status.
    always_comb
    begin
        if (mode_reg == MODE_QUOTED)
        begin
            end_status = STATUS_OPEN_QUOTE;
        end
        else if (start_reg)
        begin
            end_status = STATUS_OK;
        end
        else if (found_reg == limit_reg)
        begin
            end_status = STATUS_TOO_MANY;
        end
        else
        begin
            end_status = STATUS_OK;
        end
    end

    assign pos_wide   = (OFF_W + POS_W)'(held_pos_reg);
    assign num_wide   = (WCNT_W + NUM_W)'(held_num_reg);
    assign total_wide = (WCNT_W + TOTAL_W)'(found_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (tag_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_BETWEEN;
            bs_reg         <= 1'b0;
            offset_reg     <= '0;
            found_reg      <= '0;
            start_reg      <= 1'b1;
            held_valid_reg <= 1'b0;
            held_pos_reg   <= '0;
            held_in_reg    <= 1'b0;
            held_begin_reg <= 1'b0;
            held_end_reg   <= 1'b0;
            held_num_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                mode_reg   <= mode_next;
                bs_reg     <= bs_next;
                found_reg  <= found_next;
                if (is_end)
                begin
                    offset_reg     <= '0;
                    start_reg      <= 1'b1;
                    held_valid_reg <= 1'b0;
                    held_pos_reg   <= '0;
                    held_in_reg    <= 1'b0;
                    held_begin_reg <= 1'b0;
                    held_end_reg   <= 1'b0;
                    held_num_reg   <= '0;
                end
                else
                begin
                    if (offset_reg < OFF_W'(MAX_OFFSET - 1))
                    begin
                        offset_reg <= offset_reg + 1'b1;
                    end
                    start_reg      <= 1'b0;
                    held_valid_reg <= 1'b1;
                    held_pos_reg   <= offset_reg;
                    held_in_reg    <= cur_in;
                    held_begin_reg <= cur_begin;
                    held_end_reg   <= cur_end;
                    held_num_reg   <= cur_in ? cur_num : '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && produce)
        begin
            out_pos_reg    <= pos_wide[POS_W-1:0];
            out_in_reg     <= held_in_reg;
            out_begin_reg  <= held_begin_reg;
            out_end_reg    <= held_end_fix;
            out_num_reg    <= num_wide[NUM_W-1:0];
            out_fin_reg    <= is_end;
            out_total_reg  <= is_end ? total_wide[TOTAL_W-1:0] : '0;
            out_status_reg <= is_end ? end_status : STATUS_OK;
        end
    end

    assign tag_out.valid       = out_valid_reg;
    assign tag_out.position    = out_pos_reg;
    assign tag_out.in_word     = out_in_reg;
    assign tag_out.word_begins = out_begin_reg;
    assign tag_out.word_ends   = out_end_reg;
    assign tag_out.word_number = out_num_reg;
    assign tag_out.finished    = out_fin_reg;
    assign tag_out.word_total  = out_total_reg;
    assign tag_out.status      = out_status_reg;

endmodule

// ===== hdl/quoted_word_splitter_top.sv =====
// ----------------------------------------------------------------------------
// Quoted word splitter, top level
// Splits a zero-terminated byte stream into blank-separated and quoted words.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Payload                                  | Request
//   ---------+-----------+------------------------------------------+----------------------
//   byte_in  | in        | ch                                       | one string byte
//   tag_out  | out       | position, in_word, word_begins,          | one byte tag, or the
//            |           | word_ends, word_number, finished,        | final tag with count
//            |           | word_total, status                       | and status
//   cfg      | in        | word_capacity                            | new word table size
//
// The scanner retires queued byte requests, so the block sustains one byte per
// clock while tag_out is not stalled; the scan state update sets that figure.
// A byte is tagged one request later, since a plain word's end is only known
// when the following byte arrives; the first byte of a string returns nothing.
// Reset (rst_n low, asynchronous) empties the queue and output register and
// sets the capacity to its default; there is no clearing pass.
// A stalled tag_out holds the output register; bytes keep entering the class
// queue until it fills, and only then does byte_in drop ready.
//
`include "quoted_word_splitter_top_macros.svh"

module quoted_word_splitter_top import qws_pkg::*;
#(
    parameter int unsigned MAX_WORDS  = MAX_WORDS_DEF,
    parameter int unsigned MAX_OFFSET = MAX_OFFSET_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    qws_byte_if.sink   byte_in,
    qws_tag_if.source  tag_out,
    qws_cfg_if.sink    cfg
);

    // Front end to queue: a byte request is pushed as its class alone, which
    // is all the scanner needs to track words and quotes.
    logic        push;
    byte_class_t push_class;

    // Queue to scanner.
    logic        pop;
    byte_class_t pop_class;
    queue_stat_t q_stat;

    qws_classify u_classify
    (
        .byte_in    (byte_in),
        .q_stat     (q_stat),
        .push       (push),
        .push_class (push_class)
    );

    // The queue lets the front end keep taking bytes while the scanner waits
    // on a stalled output, and vice versa.
    qws_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_class (push_class),
        .pop        (pop),
        .pop_class  (pop_class),
        .q_stat     (q_stat)
    );

    // The scanner owns the capacity register, the word state machine and the
    // output register. It retires a queued byte whenever that byte produces no
    // tag or the output register is free or being drained in the same cycle.
    qws_scan
    #(
        .MAX_WORDS  (MAX_WORDS),
        .MAX_OFFSET (MAX_OFFSET)
    )
    u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_stat    (q_stat),
        .pop_class (pop_class),
        .pop       (pop),
        .tag_out   (tag_out)
    );

    // The queue can never report full and empty together.
    `QWS_NEVER(a_queue_full_and_empty, q_stat.full && q_stat.empty)
    // The front end never pushes into a full queue.
    `QWS_IMPLIES(a_no_push_when_full, push, !q_stat.full)
    // The scanner only retires a class that is actually queued.
    `QWS_IMPLIES(a_no_pop_when_empty, pop, !q_stat.empty)
    // A push with no pop leaves at least one class queued.
    `QWS_NEXT(a_push_fills_queue, push && !pop, !q_stat.empty)

endmodule
